[src/ac_ir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac_ir_pkg
// Constants, codes and encode functions for the air-conditioner IR frame
// builder.
// ----------------------------------------------------------------------------
package ac_ir_pkg;

  localparam int unsigned FrameBytes = 13;
  localparam int unsigned IdxW       = $clog2(FrameBytes);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameBytes - 1);

  typedef logic [7:0] byte_t;

  // Bytes of the frame before the command fields are filled in.
  localparam byte_t BaseFrame [FrameBytes] = '{
    8'hB2, 8'hAE, 8'h4D, 8'h91, 8'hF0, 8'hE1, 8'hA4,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h61, 8'h24
  };

  // Byte positions that carry command fields.
  localparam logic [IdxW-1:0] IdxModeFan = IdxW'(5);
  localparam logic [IdxW-1:0] IdxTemp    = IdxW'(6);
  localparam logic [IdxW-1:0] IdxFlags   = IdxW'(11);

  // Input mode codes.
  localparam logic [2:0] InModeCool = 3'd1;
  localparam logic [2:0] InModeDry  = 3'd2;
  localparam logic [2:0] InModeHeat = 3'd3;
  localparam logic [2:0] InModeFan  = 3'd4;

  // Input fan speed codes.
  localparam logic [1:0] InFanAuto = 2'd0;
  localparam logic [1:0] InFanLow  = 2'd1;
  localparam logic [1:0] InFanMed  = 2'd2;
  localparam logic [1:0] InFanHigh = 2'd3;

  typedef enum logic [3:0] {
    MODE_DRY  = 4'h2,
    MODE_FAN  = 4'h4,
    MODE_COOL = 4'h6,
    MODE_HEAT = 4'h9,
    MODE_AUTO = 4'hE
  } mode_code_e;

  typedef enum logic [3:0] {
    FAN_AUTO = 4'h1,
    FAN_HIGH = 4'h2,
    FAN_MED  = 4'h4,
    FAN_LOW  = 4'h8
  } fan_code_e;

  localparam logic [7:0] TempMin   = 8'd16;
  localparam logic [7:0] TempMax   = 8'd32;
  localparam logic [7:0] TempAuto  = 8'd25;
  localparam logic [7:0] TempDelta = 8'd7;

  // Command as held in the input register.
  typedef struct packed {
    logic [2:0] ac_mode;
    logic [1:0] fan_speed;
    logic [7:0] temp_c;
    logic       power;
    logic       swing;
  } cmd_t;

  function automatic mode_code_e mode_code(input logic [2:0] m);
    mode_code_e r;
    unique case (m)
      InModeCool: r = MODE_COOL;
      InModeDry:  r = MODE_DRY;
      InModeHeat: r = MODE_HEAT;
      InModeFan:  r = MODE_FAN;
      default:    r = MODE_AUTO;
    endcase
    return r;
  endfunction

  function automatic fan_code_e fan_code(input logic [1:0] f, input mode_code_e m);
    fan_code_e r;
    unique case (f)
      InFanLow:  r = FAN_LOW;
      InFanMed:  r = FAN_MED;
      InFanHigh: r = FAN_HIGH;
      default:   r = (m == MODE_HEAT || m == MODE_FAN) ? FAN_LOW : FAN_AUTO;
    endcase
    if (m == MODE_AUTO) r = FAN_AUTO;
    if (m == MODE_DRY) r = FAN_LOW;
    return r;
  endfunction

  function automatic logic [4:0] temp_code(input logic [7:0] t, input mode_code_e m);
    logic [7:0] tc;
    logic [7:0] td;
    logic [4:0] r;
    tc = (m == MODE_AUTO) ? TempAuto : t;
    if (tc < TempMin) tc = TempMin;
    if (tc > TempMax) tc = TempMax;
    td = tc - TempDelta;
    for (int i = 0; i < 5; i++) begin
      r[4-i] = td[i];
    end
    return r;
  endfunction

  function automatic logic [3:0] rev4(input logic [3:0] v);
    return {v[0], v[1], v[2], v[3]};
  endfunction

  function automatic byte_t rev8(input byte_t v);
    byte_t r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // Sum of the bit-reversed nibbles of one byte.
  function automatic byte_t nib_sum(input byte_t v);
    return byte_t'(rev4(v[3:0])) + byte_t'(rev4(v[7:4]));
  endfunction

endpackage

[src/ac_remote_ir_frame_builder.sv]
`timescale 1ns / 1ps
// A command passes through the input register, the frame byte registers and
// the output register before its first byte shows on the master side; the
// following bytes go out one per cycle while m_axis_tready is high, and the
// next command is taken while a frame is still being sent.
// Reset clears all valid flags and the byte counter; no frame is in flight.
// ----------------------------------------------------------------------------
// ac_remote_ir_frame_builder
// Encodes one air-conditioner command into a 13-byte IR frame, one byte per
// output item, with tlast on the checksum byte.
// ----------------------------------------------------------------------------
module ac_remote_ir_frame_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ac_mode[2:0], fan_speed[4:3], temp_c[12:5], power[13], swing[14], zero[15]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame_byte[7:0], byte_index[11:8], zero[15:12]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import ac_ir_pkg::*;

  cmd_t            cmd_q;
  logic            cmd_vld_q;
  logic            cmd_take;
  logic            in_acc;

  byte_t           b5_q, b6_q, b11_q, b12_q;
  byte_t           b5_d, b6_d, b11_d, b12_d;
  logic [IdxW-1:0] idx_q;
  logic            frm_vld_q;
  logic            frm_free;
  logic            emit;

  byte_t           out_byte_q;
  logic [IdxW-1:0] out_idx_q;
  logic            out_last_q;
  logic            out_vld_q;
  logic            out_free;
  byte_t           sel_byte;

  mode_code_e      mcode;
  fan_code_e       fcode;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign emit          = frm_vld_q && out_free;
  assign frm_free      = !frm_vld_q || (emit && idx_q == LastIdx);
  assign cmd_take      = cmd_vld_q && frm_free;
  assign s_axis_tready = !cmd_vld_q || frm_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    mcode = mode_code(cmd_q.ac_mode);
    fcode = fan_code(cmd_q.fan_speed, mcode);
    b5_d  = {mcode, fcode};
    b6_d  = (BaseFrame[IdxTemp] & 8'h83) | {1'b0, temp_code(cmd_q.temp_c, mcode), 2'b00};
    b11_d = (BaseFrame[IdxFlags] & 8'h9F) | {1'b0, cmd_q.swing, cmd_q.power, 5'b0};
    b12_d = rev8(nib_sum(b5_d) + nib_sum(b6_d) + nib_sum(b11_d));
  end

  always_comb begin
    case (idx_q)
      IdxModeFan: sel_byte = b5_q;
      IdxTemp:    sel_byte = b6_q;
      IdxFlags:   sel_byte = b11_q;
      LastIdx:    sel_byte = b12_q;
      default:    sel_byte = BaseFrame[idx_q];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      frm_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cmd_vld_q <= 1'b1;
      end else if (cmd_take) begin
        cmd_vld_q <= 1'b0;
      end
      if (cmd_take) begin
        frm_vld_q <= 1'b1;
        idx_q     <= '0;
      end else if (emit) begin
        if (idx_q == LastIdx) begin
          frm_vld_q <= 1'b0;
          idx_q     <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (out_free) begin
        out_vld_q <= frm_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= '{ac_mode:   s_axis_tdata[2:0],
                 fan_speed: s_axis_tdata[4:3],
                 temp_c:    s_axis_tdata[12:5],
                 power:     s_axis_tdata[13],
                 swing:     s_axis_tdata[14]};
    end
    if (cmd_take) begin
      b5_q  <= b5_d;
      b6_q  <= b6_d;
      b11_q <= b11_d;
      b12_q <= b12_d;
    end
    if (emit) begin
      out_byte_q <= sel_byte;
      out_idx_q  <= idx_q;
      out_last_q <= (idx_q == LastIdx);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_idx_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frm_vld_q |-> idx_q <= LastIdx)
    else $error("frame byte counter out of range");

  a_load_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take |=> frm_vld_q && idx_q == '0)
    else $error("loaded frame does not start at byte zero");

  a_last_is_checksum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_last_q == (out_idx_q == LastIdx)))
    else $error("last flag not on the checksum byte");

  a_frame_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && m_axis_tready && !out_last_q |=> out_vld_q)
    else $error("gap inside a frame");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends air-conditioner commands into the IR frame builder and checks every
// frame byte, its position and tlast against frames computed in the bench.
// A short table covers every mode, every fan speed, the unknown modes and the
// temperature clamps. Random commands follow, with random stalls on both
// sides, one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module testbench;
  import ac_ir_pkg::*;

  localparam int unsigned RandomCmds = 250;
  localparam int unsigned CalmFrom   = 200;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CycleLimit = 200000;

  // A zero byte in the table means the byte is computed, not typed in.
  localparam byte_t Computed = 8'h00;

  localparam logic [2:0] InModeAuto   = 3'd0;
  localparam logic [2:0] InModeSpare5 = 3'd5;
  localparam logic [2:0] InModeSpare6 = 3'd6;
  localparam logic [2:0] InModeSpare7 = 3'd7;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] fan;
    logic [7:0] temp;
    logic       power;
    logic       swing;
    byte_t      want_mode_fan;
    byte_t      want_temp;
  } cmd_row_t;

  typedef struct {
    byte_t           value;
    logic [IdxW-1:0] index;
    logic            last;
  } frame_byte_t;

  localparam cmd_row_t DirectedRows [19] = '{
    '{InModeAuto,   InFanAuto, 8'd0,   1'b0, 1'b0, {MODE_AUTO, FAN_AUTO}, 8'hA4},
    '{InModeAuto,   InFanHigh, 8'd255, 1'b1, 1'b1, {MODE_AUTO, FAN_AUTO}, 8'hA4},
    '{InModeCool,   InFanAuto, 8'd16,  1'b1, 1'b0, {MODE_COOL, FAN_AUTO}, 8'hC8},
    '{InModeCool,   InFanLow,  8'd0,   1'b0, 1'b1, {MODE_COOL, FAN_LOW},  8'hC8},
    '{InModeCool,   InFanMed,  8'd32,  1'b1, 1'b1, {MODE_COOL, FAN_MED},  8'hCC},
    '{InModeCool,   InFanHigh, 8'd255, 1'b0, 1'b0, {MODE_COOL, FAN_HIGH}, 8'hCC},
    '{InModeDry,    InFanHigh, 8'd20,  1'b1, 1'b0, {MODE_DRY,  FAN_LOW},  Computed},
    '{InModeDry,    InFanAuto, 8'd24,  1'b0, 1'b1, {MODE_DRY,  FAN_LOW},  Computed},
    '{InModeHeat,   InFanAuto, 8'd30,  1'b1, 1'b1, {MODE_HEAT, FAN_LOW},  Computed},
    '{InModeHeat,   InFanMed,  8'd128, 1'b1, 1'b0, {MODE_HEAT, FAN_MED},  8'hCC},
    '{InModeFan,    InFanAuto, 8'd22,  1'b0, 1'b0, {MODE_FAN,  FAN_LOW},  Computed},
    '{InModeFan,    InFanHigh, 8'd27,  1'b1, 1'b1, {MODE_FAN,  FAN_HIGH}, Computed},
    '{InModeSpare5, InFanMed,  8'd17,  1'b1, 1'b0, {MODE_AUTO, FAN_AUTO}, 8'hA4},
    '{InModeSpare6, InFanLow,  8'd31,  1'b0, 1'b1, {MODE_AUTO, FAN_AUTO}, 8'hA4},
    '{InModeSpare7, InFanHigh, 8'd0,   1'b1, 1'b1, {MODE_AUTO, FAN_AUTO}, 8'hA4},
    '{InModeCool,   InFanLow,  8'd15,  1'b1, 1'b0, {MODE_COOL, FAN_LOW},  8'hC8},
    '{InModeCool,   InFanLow,  8'd33,  1'b0, 1'b1, {MODE_COOL, FAN_LOW},  8'hCC},
    '{InModeCool,   InFanMed,  8'd25,  1'b1, 1'b1, {MODE_COOL, FAN_MED},  8'hA4},
    '{InModeHeat,   InFanLow,  8'd19,  1'b0, 1'b0, {MODE_HEAT, FAN_LOW},  Computed}
  };

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  frame_byte_t expected_bytes [$];
  int unsigned mismatches   = 0;
  int unsigned cycles       = 0;
  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;

  ac_remote_ir_frame_builder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < 40) begin
      $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // Builds the frame for one command and queues its bytes in send order.
  function automatic void queue_frame(input cmd_row_t r);
    byte_t       fr [FrameBytes];
    mode_code_e  mode;
    fan_code_e   fan;
    logic [7:0]  t;
    logic [4:0]  code;
    byte_t       sum;
    frame_byte_t fb;
    int          k;
    for (k = 0; k < FrameBytes; k++) begin
      fr[k] = BaseFrame[k];
    end
    case (r.mode)
      InModeCool: mode = MODE_COOL;
      InModeDry:  mode = MODE_DRY;
      InModeHeat: mode = MODE_HEAT;
      InModeFan:  mode = MODE_FAN;
      default:    mode = MODE_AUTO;
    endcase
    if (mode == MODE_AUTO) begin
      fan = FAN_AUTO;
    end else if (mode == MODE_DRY) begin
      fan = FAN_LOW;
    end else begin
      case (r.fan)
        InFanLow:  fan = FAN_LOW;
        InFanMed:  fan = FAN_MED;
        InFanHigh: fan = FAN_HIGH;
        default:   fan = (mode == MODE_HEAT || mode == MODE_FAN) ? FAN_LOW : FAN_AUTO;
      endcase
    end
    t = (mode == MODE_AUTO) ? TempAuto : r.temp;
    if (t < TempMin) begin
      t = TempMin;
    end else if (t > TempMax) begin
      t = TempMax;
    end
    t = t - TempDelta;
    for (k = 0; k < 5; k++) begin
      code[4-k] = t[k];
    end
    fr[IdxModeFan] = (r.want_mode_fan != Computed) ? r.want_mode_fan : {mode, fan};
    fr[IdxTemp] = (r.want_temp != Computed) ? r.want_temp
                                            : (fr[IdxTemp] & 8'h83) | {1'b0, code, 2'b00};
    fr[IdxFlags][5] = r.power;
    fr[IdxFlags][6] = r.swing;
    sum = '0;
    for (k = IdxModeFan; k <= IdxFlags; k++) begin
      sum = sum + byte_t'({fr[k][0], fr[k][1], fr[k][2], fr[k][3]})
                + byte_t'({fr[k][4], fr[k][5], fr[k][6], fr[k][7]});
    end
    for (k = 0; k < 8; k++) begin
      fr[FrameBytes-1][7-k] = sum[k];
    end
    for (k = 0; k < FrameBytes; k++) begin
      fb.value = fr[k];
      fb.index = IdxW'(k);
      fb.last  = (k == FrameBytes - 1);
      expected_bytes.push_back(fb);
    end
  endfunction

  task automatic offer_cmd(input cmd_row_t r);
    s_axis_tdata  <= {1'b0, r.swing, r.power, r.temp, r.fan, r.mode};
    s_axis_tvalid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    queue_frame(r);
  endtask

  always @(posedge clk_i) begin : frame_check
    frame_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("byte with no frame pending", m_axis_tdata, 0);
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata[7:0] !== want.value) begin
          report_mismatch("frame byte", m_axis_tdata[7:0], want.value);
        end
        if (m_axis_tdata[11:8] !== want.index) begin
          report_mismatch("byte index", m_axis_tdata[11:8], want.index);
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("tlast", m_axis_tlast, want.last);
        end
      end
    end
  end

  initial begin : sink
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      n = $urandom_range(1, 16);
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    cmd_row_t    r;
    int unsigned n;
    int unsigned i;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (i = 0; i < $size(DirectedRows); i++) begin
      if ($urandom_range(0, 3) == 0) begin
        s_axis_tvalid <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk_i);
      end
      offer_cmd(DirectedRows[i]);
    end
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    hold_request = 1'b1;
    for (i = 0; i < RandomCmds; i++) begin
      if (i == CalmFrom) begin
        calm = 1'b1;
      end
      r.mode  = 3'($urandom_range(0, 7));
      r.fan   = 2'($urandom_range(0, 3));
      r.temp  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(12, 36));
      r.power = 1'($urandom_range(0, 1));
      r.swing = 1'($urandom_range(0, 1));
      r.want_mode_fan = Computed;
      r.want_temp     = Computed;
      if (!calm && $urandom_range(0, 3) == 0) begin
        s_axis_tvalid <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk_i);
      end
      offer_cmd(r);
    end
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
